FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)

`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

FILE: rtl/sha1md_pkg.sv
// Types, constants and helpers of the SHA-1 message digest block.
package sha1md_pkg;

    localparam logic [0:4][31:0] INIT_H = {
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [5:0] FILL_LAST      = 6'd63;
    localparam logic [5:0] FILL_LEN_START = 6'd56;
    localparam logic [6:0] ROUND_LAST     = 7'd79;
    localparam logic [6:0] ROUND_SCHED    = 7'd16;
    localparam logic [6:0] ROUND_GRP1     = 7'd20;
    localparam logic [6:0] ROUND_GRP2     = 7'd40;
    localparam logic [6:0] ROUND_GRP3     = 7'd60;
    localparam logic [2:0] LEN_LAST       = 3'd7;
    localparam logic [2:0] WORD_LAST      = 3'd4;
    localparam logic [7:0] PAD_BYTE       = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_PAD80,
        ST_ZERO,
        ST_LEN,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_INPUT,
        SEL_PAD,
        SEL_ZERO,
        SEL_LEN
    } byte_sel_t;

    typedef struct packed {
        byte_sel_t   byte_sel;
        logic        count_bits;
        logic [2:0]  len_idx;
        logic        init_work;
        logic        round_step;
        logic [6:0]  round_idx;
        logic        chain_add;
        logic        msg_clear;
        logic [2:0]  word_sel;
    } cmd_t;

    typedef struct packed {
        logic fill_last;
        logic fill_at_len;
    } stat_t;

    function automatic logic [31:0] round_k(input logic [1:0] grp);
        logic [31:0] k;
        unique case (grp)
            2'd0: k = 32'h5A827999;
            2'd1: k = 32'h6ED9EBA1;
            2'd2: k = 32'h8F1BBCDC;
            default: k = 32'hCA62C1D6;
        endcase
        return k;
    endfunction

endpackage

FILE: rtl/sha1_message_digest.sv
// SHA-1 message digest: top level joining controller and datapath.
//
// Input channel s_*: one item per message byte. s_tdata is the byte, s_tuser
// flags it as a real byte (0 = no byte), s_tlast closes the message after it.
// Output channel m_*: five items per message, the 160-bit digest as 32-bit
// words, most significant first; m_tuser is the word index, m_tlast the fifth.
// An item is taken while s_tready is high, in the idle state. Every
// 64th byte starts an 80-round compression, one round per cycle on the shared
// round unit, then a fold into the chaining value; s_tready is low throughout,
// so no byte is taken while a compression runs. At message end the padding
// sequencer writes the 0x80 byte, zeros and eight length bytes one per cycle
// except while a compression runs, and writes no byte in the step before the
// length bytes. Each block is compressed when full; then the digest is shown.
// s_tready is low from message end until the fifth word is taken; a stalled
// receiver holds the current word and the block takes no new item meanwhile.
// Reset is synchronous (aresetn low): chaining value back to the initial
// constants, byte and bit counts to zero, no clearing pass. After the last
// word is taken the block is ready for the next message.
`include "assert_macros.svh"

module sha1_message_digest (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] byte_valid
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] digest_word
    output logic [2:0]  m_tuser,    // [2:0] word_index
    output logic        m_tlast
);

    sha1md_pkg::cmd_t  cmd;
    sha1md_pkg::stat_t stat;
    logic              dp_busy;
    logic              word_mid_taken;
    logic [2:0]        idx_step;

    sha1md_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .byte_valid  (s_tuser),
        .message_end (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .word_index  (m_tuser),
        .last_word   (m_tlast),
        .stat        (stat),
        .cmd         (cmd)
    );

    sha1md_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .byte_in     (s_tdata),
        .stat        (stat),
        .digest_word (m_tdata)
    );

    assign dp_busy        = cmd.round_step || cmd.chain_add;
    assign word_mid_taken = m_tvalid && m_tready && !m_tlast;
    assign idx_step       = m_tuser + 3'd1;

    `ASSERT_IMPLIES(a_no_overlap, aclk, aresetn, m_tvalid, !s_tready)
    `ASSERT_IMPLIES(a_round_busy, aclk, aresetn, dp_busy, !s_tready && !m_tvalid)
    `ASSERT_IMPLIES(a_last_index, aclk, aresetn, m_tvalid && m_tlast, m_tuser == sha1md_pkg::WORD_LAST)
    `ASSERT_NEXT(a_word_step, aclk, aresetn, word_mid_taken, m_tvalid && (m_tuser == $past(idx_step)))

endmodule

FILE: rtl/sha1md_datapath.sv
// Datapath: block window, message schedule, round registers, chaining value, bit count.
module sha1md_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  sha1md_pkg::cmd_t    cmd,
    input  logic [7:0]          byte_in,
    output sha1md_pkg::stat_t   stat,
    output logic [31:0]         digest_word
);

    localparam logic [2:0] LEN_LAST_C = sha1md_pkg::LEN_LAST;

    logic [0:15][31:0] win_reg, win_next;
    logic [0:4][31:0]  work_reg, work_next;
    logic [0:4][31:0]  chain_reg, chain_next;
    logic [5:0]        fill_reg, fill_next;
    logic [63:0]       bits_reg, bits_next;

    logic [7:0]  byte_mux;
    logic [63:0] len_shift;
    logic [31:0] w_tap, w_cur, f_val, t_val, a_rot;
    logic [1:0]  grp;

    always_comb begin
        len_shift = bits_reg >> {3'(LEN_LAST_C - cmd.len_idx), 3'b000};
    end

    always_comb begin
        unique case (cmd.byte_sel)
            sha1md_pkg::SEL_INPUT: byte_mux = byte_in;
            sha1md_pkg::SEL_PAD:   byte_mux = sha1md_pkg::PAD_BYTE;
            sha1md_pkg::SEL_LEN:   byte_mux = len_shift[7:0];
            default:               byte_mux = 8'h00;
        endcase
    end

    always_comb begin
        w_tap = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
        w_cur = (cmd.round_idx < sha1md_pkg::ROUND_SCHED) ? win_reg[0]
                                                          : {w_tap[30:0], w_tap[31]};
        if (cmd.round_idx < sha1md_pkg::ROUND_GRP1) begin
            grp = 2'd0;
        end else if (cmd.round_idx < sha1md_pkg::ROUND_GRP2) begin
            grp = 2'd1;
        end else if (cmd.round_idx < sha1md_pkg::ROUND_GRP3) begin
            grp = 2'd2;
        end else begin
            grp = 2'd3;
        end
        unique case (grp)
            2'd0: f_val = (work_reg[1] & work_reg[2]) ^ (~work_reg[1] & work_reg[3]);
            2'd2: f_val = (work_reg[1] & work_reg[2]) ^ (work_reg[1] & work_reg[3])
                        ^ (work_reg[2] & work_reg[3]);
            default: f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
        endcase
        a_rot = {work_reg[0][26:0], work_reg[0][31:27]};
        t_val = a_rot + f_val + work_reg[4] + sha1md_pkg::round_k(grp) + w_cur;
    end

    always_comb begin
        win_next   = win_reg;
        work_next  = work_reg;
        chain_next = chain_reg;
        fill_next  = fill_reg;
        bits_next  = bits_reg;
        if (cmd.byte_sel != sha1md_pkg::SEL_NONE) begin
            win_next  = {win_reg[0][23:0], win_reg[1:15], byte_mux};
            fill_next = fill_reg + 6'd1;
        end
        if (cmd.count_bits) begin
            bits_next = bits_reg + 64'd8;
        end
        if (cmd.init_work) begin
            work_next = chain_reg;
        end
        if (cmd.round_step) begin
            win_next  = {win_reg[1:15], w_cur};
            work_next = {t_val, work_reg[0], {work_reg[1][1:0], work_reg[1][31:2]},
                         work_reg[2], work_reg[3]};
        end
        if (cmd.chain_add) begin
            for (int i = 0; i < 5; i++) begin
                chain_next[i] = chain_reg[i] + work_reg[i];
            end
        end
        if (cmd.msg_clear) begin
            chain_next = sha1md_pkg::INIT_H;
            fill_next  = 6'd0;
            bits_next  = 64'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg <= sha1md_pkg::INIT_H;
            fill_reg  <= 6'd0;
            bits_reg  <= 64'd0;
        end else begin
            chain_reg <= chain_next;
            fill_reg  <= fill_next;
            bits_reg  <= bits_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg  <= win_next;
        work_reg <= work_next;
    end

    always_comb begin
        stat.fill_last   = (fill_reg == sha1md_pkg::FILL_LAST);
        stat.fill_at_len = (fill_reg == sha1md_pkg::FILL_LEN_START);
    end

    always_comb begin
        unique case (cmd.word_sel)
            3'd0: digest_word = chain_reg[0];
            3'd1: digest_word = chain_reg[1];
            3'd2: digest_word = chain_reg[2];
            3'd3: digest_word = chain_reg[3];
            default: digest_word = chain_reg[4];
        endcase
    end

endmodule

FILE: rtl/sha1md_ctrl.sv
// Controller: byte intake, padding sequence, round counter and digest readout.
module sha1md_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                byte_valid,
    input  logic                message_end,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [2:0]          word_index,
    output logic                last_word,
    input  sha1md_pkg::stat_t   stat,
    output sha1md_pkg::cmd_t    cmd
);

    sha1md_pkg::state_t state_reg, state_next;
    sha1md_pkg::state_t ret_reg, ret_next;
    logic [6:0] round_reg, round_next;
    logic [2:0] len_reg, len_next;
    logic [2:0] word_reg, word_next;
    logic       accept;
    logic       out_done;

    assign accept   = s_tvalid && (state_reg == sha1md_pkg::ST_IDLE);
    assign out_done = (state_reg == sha1md_pkg::ST_OUT) && m_tready
                      && (word_reg == sha1md_pkg::WORD_LAST);

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            sha1md_pkg::ST_IDLE: begin
                if (accept) begin
                    if (byte_valid && stat.fill_last) begin
                        state_next = sha1md_pkg::ST_ROUND;
                        ret_next   = message_end ? sha1md_pkg::ST_PAD80 : sha1md_pkg::ST_IDLE;
                    end else if (message_end) begin
                        state_next = sha1md_pkg::ST_PAD80;
                    end
                end
            end
            sha1md_pkg::ST_ROUND: begin
                if (round_reg == sha1md_pkg::ROUND_LAST) begin
                    state_next = sha1md_pkg::ST_FINAL;
                end
            end
            sha1md_pkg::ST_FINAL: begin
                state_next = ret_reg;
            end
            sha1md_pkg::ST_PAD80: begin
                if (stat.fill_last) begin
                    state_next = sha1md_pkg::ST_ROUND;
                    ret_next   = sha1md_pkg::ST_ZERO;
                end else begin
                    state_next = sha1md_pkg::ST_ZERO;
                end
            end
            sha1md_pkg::ST_ZERO: begin
                if (stat.fill_at_len) begin
                    state_next = sha1md_pkg::ST_LEN;
                end else if (stat.fill_last) begin
                    state_next = sha1md_pkg::ST_ROUND;
                    ret_next   = sha1md_pkg::ST_ZERO;
                end
            end
            sha1md_pkg::ST_LEN: begin
                if (len_reg == sha1md_pkg::LEN_LAST) begin
                    state_next = sha1md_pkg::ST_ROUND;
                    ret_next   = sha1md_pkg::ST_OUT;
                end
            end
            sha1md_pkg::ST_OUT: begin
                if (out_done) begin
                    state_next = sha1md_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sha1md_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        round_next = (state_reg == sha1md_pkg::ST_ROUND) ? round_reg + 7'd1 : 7'd0;
        len_next   = (state_reg == sha1md_pkg::ST_LEN) ? len_reg + 3'd1 : 3'd0;
        word_next  = word_reg;
        if ((state_reg == sha1md_pkg::ST_OUT) && m_tready) begin
            word_next = (word_reg == sha1md_pkg::WORD_LAST) ? 3'd0 : word_reg + 3'd1;
        end
    end

    always_comb begin
        cmd            = '0;
        cmd.byte_sel   = sha1md_pkg::SEL_NONE;
        cmd.len_idx    = len_reg;
        cmd.round_idx  = round_reg;
        cmd.word_sel   = word_reg;
        cmd.init_work  = (state_next == sha1md_pkg::ST_ROUND)
                         && (state_reg != sha1md_pkg::ST_ROUND);
        s_tready       = (state_reg == sha1md_pkg::ST_IDLE);
        m_tvalid       = (state_reg == sha1md_pkg::ST_OUT);
        word_index     = word_reg;
        last_word      = (word_reg == sha1md_pkg::WORD_LAST);
        unique case (state_reg)
            sha1md_pkg::ST_IDLE: begin
                if (accept && byte_valid) begin
                    cmd.byte_sel   = sha1md_pkg::SEL_INPUT;
                    cmd.count_bits = 1'b1;
                end
            end
            sha1md_pkg::ST_ROUND: begin
                cmd.round_step = 1'b1;
            end
            sha1md_pkg::ST_FINAL: begin
                cmd.chain_add = 1'b1;
            end
            sha1md_pkg::ST_PAD80: begin
                cmd.byte_sel = sha1md_pkg::SEL_PAD;
            end
            sha1md_pkg::ST_ZERO: begin
                if (!stat.fill_at_len) begin
                    cmd.byte_sel = sha1md_pkg::SEL_ZERO;
                end
            end
            sha1md_pkg::ST_LEN: begin
                cmd.byte_sel = sha1md_pkg::SEL_LEN;
            end
            sha1md_pkg::ST_OUT: begin
                cmd.msg_clear = out_done;
            end
            default: begin
                cmd.msg_clear = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sha1md_pkg::ST_IDLE;
            ret_reg   <= sha1md_pkg::ST_IDLE;
            round_reg <= 7'd0;
            len_reg   <= 3'd0;
            word_reg  <= 3'd0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            round_reg <= round_next;
            len_reg   <= len_next;
            word_reg  <= word_next;
        end
    end

endmodule

FILE: tb/sha1_message_digest_tb.sv
// Self-checking testbench for the SHA-1 message digest block, known answers plus a SHA-1 model.
module sha1_message_digest_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RAND_ITEMS   = 420;
    localparam int DRAIN_CYCLES = 400;
    localparam int DIR_N        = 13;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_MARK  = 8'h80;
    localparam int          LEN_FIELD = 56;

    localparam logic [159:0] DIGEST_EMPTY =
        160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
    localparam logic [159:0] DIGEST_ABC =
        160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_word_t;

    typedef struct packed {
        logic [7:0]   data;
        logic         byte_valid;
        logic         msg_end;
        logic         known;
        logic [159:0] digest;
    } dir_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // model state
    logic [31:0] chain [5];
    logic [7:0]  msg_block [64];
    logic [5:0]  msg_fill;
    logic [63:0] msg_bits;

    digest_word_t expected_words [$];

    int send_pct  = 0;
    int stall_pct = 0;
    int errors    = 0;
    int words_checked = 0;
    int bytes_sent = 0;
    int messages_sent = 0;
    int cycle_count = 0;

    dir_row_t dir_rows [DIR_N] = '{
        '{8'h00, 1'b0, 1'b0, 1'b0, 160'h0},          // idle
        '{8'hA5, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},    // empty message
        '{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h63, 1'b1, 1'b1, 1'b1, DIGEST_ABC},      // byte then end
        '{8'hFF, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 160'h0},          // idle inside a message
        '{8'h00, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h5A, 1'b0, 1'b1, 1'b0, 160'h0},          // end with no byte
        '{8'hFF, 1'b1, 1'b1, 1'b0, 160'h0},
        '{8'h00, 1'b1, 1'b1, 1'b0, 160'h0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 160'h0},
        '{8'h3C, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY}
    };

    sha1_message_digest uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void sha1_restart();
        chain[0] = H0;
        chain[1] = H1;
        chain[2] = H2;
        chain[3] = H3;
        chain[4] = H4;
        msg_fill = '0;
        msg_bits = '0;
        for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    endfunction

    function automatic void sha1_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t, wt;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int r = 0; r < 80; r++) begin
            if (r >= 16) begin
                wt = w[(r + 13) & 15] ^ w[(r + 8) & 15] ^ w[(r + 2) & 15] ^ w[r & 15];
                w[r & 15] = rotl32(wt, 1);
            end
            wt = w[r & 15];
            if (r < 20) begin
                f = (b & c) ^ (~b & d);
                k = K0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = K1;
            end else if (r < 60) begin
                f = (b & c) ^ (b & d) ^ (c & d);
                k = K2;
            end else begin
                f = b ^ c ^ d;
                k = K3;
            end
            t = rotl32(a, 5) + f + e + k + wt;
            e = d;
            d = c;
            c = rotl32(b, 30);
            b = a;
            a = t;
        end
        chain[0] = chain[0] + a;
        chain[1] = chain[1] + b;
        chain[2] = chain[2] + c;
        chain[3] = chain[3] + d;
        chain[4] = chain[4] + e;
    endfunction

    // absorbs one item; returns 1 and the digest when the message closes
    function automatic int sha1_absorb(input logic [7:0] b, input logic v, input logic e,
                                       output logic [159:0] dig);
        int i;
        dig = '0;
        if (v) begin
            msg_block[msg_fill] = b;
            msg_bits = msg_bits + 64'd8;
            msg_fill = msg_fill + 6'd1;
            if (msg_fill == 6'd0) sha1_compress();
        end
        if (!e) return 0;
        i = msg_fill;
        msg_block[i] = PAD_MARK;
        i++;
        if (i > LEN_FIELD) begin
            while (i < 64) begin
                msg_block[i] = 8'h00;
                i++;
            end
            sha1_compress();
            i = 0;
        end
        while (i < LEN_FIELD) begin
            msg_block[i] = 8'h00;
            i++;
        end
        for (int j = 0; j < 8; j++) msg_block[63 - j] = msg_bits[8*j +: 8];
        sha1_compress();
        dig = {chain[0], chain[1], chain[2], chain[3], chain[4]};
        sha1_restart();
        return 1;
    endfunction

    function automatic void push_digest(input logic [159:0] dig);
        digest_word_t w;
        for (int k = 0; k < 5; k++) begin
            w.word = dig[159 - 32*k -: 32];
            w.idx  = 3'(k);
            w.last = (k == 4);
            expected_words.push_back(w);
        end
    endfunction

    // drives one item, waits for acceptance, then updates the model
    task automatic send_item(input logic [7:0] b, input logic v, input logic e,
                             input logic known, input logic [159:0] known_dig);
        logic [159:0] dig;
        int closed;
        while ($urandom_range(0, 99) < send_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= v;
        s_tlast  <= e;
        do @(posedge aclk); while (!s_tready);
        closed = sha1_absorb(b, v, e, dig);
        if (v) bytes_sent++;
        if (closed != 0) begin
            messages_sent++;
            push_digest(known ? known_dig : dig);
        end
    endtask

    always @(posedge aclk) m_tready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge aclk) begin : out_check
        digest_word_t exp_w;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected digest word: got %h idx %0d last %0d",
                         $time, m_tdata, m_tuser, m_tlast);
                errors++;
            end else begin
                exp_w = expected_words.pop_front();
                words_checked++;
                if (m_tdata !== exp_w.word) begin
                    $display("%0t: digest word mismatch: expected %h, got %h",
                             $time, exp_w.word, m_tdata);
                    errors++;
                end
                if (m_tuser !== exp_w.idx) begin
                    $display("%0t: word index mismatch: expected %0d, got %0d",
                             $time, exp_w.idx, m_tuser);
                    errors++;
                end
                if (m_tlast !== exp_w.last) begin
                    $display("%0t: last word flag mismatch: expected %0d, got %0d",
                             $time, exp_w.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d digest words still pending",
                     $time, expected_words.size());
            $display("FAIL sha1_message_digest");
            $finish;
        end
    end

    initial begin : stimulus
        int items;
        int msg_no;
        int len;
        int pick;
        logic end_on_byte;
        sha1_restart();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < DIR_N; r++)
            send_item(dir_rows[r].data, dir_rows[r].byte_valid, dir_rows[r].msg_end,
                      dir_rows[r].known, dir_rows[r].digest);

        items  = 0;
        msg_no = 0;
        while (items < RAND_ITEMS) begin
            case (msg_no % 4)
                0: begin
                    send_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    send_pct  = 60;
                    stall_pct = 0;
                end
                2: begin
                    send_pct  = 0;
                    stall_pct = 60;
                end
                default: begin
                    send_pct  = 34;
                    stall_pct = 34;
                end
            endcase
            // mostly short messages, many near the one/two block padding edge
            pick = $urandom_range(0, 99);
            if (pick < 55)      len = $urandom_range(0, 8);
            else if (pick < 90) len = $urandom_range(52, 66);
            else                len = $urandom_range(115, 130);
            end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
            for (int n = 0; n < len; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
                    items++;
                end
                send_item(8'($urandom_range(0, 255)), 1'b1,
                          end_on_byte && (n == len - 1), 1'b0, '0);
                items++;
            end
            if (!end_on_byte) begin
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
                items++;
            end
            msg_no++;
        end

        s_tvalid  <= 1'b0;
        stall_pct = 0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d messages, %0d bytes, %0d digest words compared",
                 messages_sent, bytes_sent, words_checked);
        $display("idle items, end-only items and sender/receiver stall phases included");
        if (errors == 0) begin
            $display("PASS sha1_message_digest");
        end else begin
            $display("FAIL sha1_message_digest");
        end
        $finish;
    end

endmodule

FILE: sha1_message_digest.f
+incdir+rtl
rtl/sha1md_pkg.sv
rtl/sha1md_datapath.sv
rtl/sha1md_ctrl.sv
rtl/sha1_message_digest.sv
tb/sha1_message_digest_tb.sv
